// ===== src/mtpd_pkg.sv =====
// Package for the median threshold peak detector.
// Holds sizes, register codes and the cell data and control types.
// No dependencies.
package mtpd_pkg;

    localparam int CHANNELS    = 10;
    localparam int MEDIAN_RANK = 4;
    localparam int POWER_WIDTH = 32;

    localparam int CH_W     = 4;
    localparam int PWR_IN_W = 32;
    localparam int PW       = (POWER_WIDTH < PWR_IN_W) ? POWER_WIDTH : PWR_IN_W;
    localparam int CNT_W    = 16;
    localparam int FUDGE_W  = 16;
    localparam int MASK_W   = 10;
    localparam int THR_W    = PW + FUDGE_W;
    localparam int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PH_W     = $clog2(CHANNELS + 1);
    localparam int RANK     = (MEDIAN_RANK < CHANNELS) ? MEDIAN_RANK : CHANNELS - 1;

    localparam logic [FUDGE_W-1:0] FUDGE_RESET = FUDGE_W'(750);
    localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FUDGE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE_ALL = 2'd2;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [PW-1:0]    pwr;
        logic [CNT_W-1:0] cnt;
    } cell_t;

    typedef struct packed {
        logic             wr_en;
        logic [CH_W-1:0]  wr_ch;
        logic [PW-1:0]    wr_pwr;
        logic             sort_en;
        logic             phase;
        logic             inc_en;
        logic [CW-1:0]    inc_idx;
    } cell_ctl_t;

endpackage

// ===== src/mtpd_cell.sv =====
// One sorting cell: holds a channel id, its power and its hit counter.
// Compare-exchange with a neighbor on alternating phases (odd-even sort).
// Depends on mtpd_pkg.
module mtpd_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [mtpd_pkg::CW-1:0]   idx,
    input  mtpd_pkg::cell_ctl_t       ctl,
    input  mtpd_pkg::cell_t           left_in,
    input  mtpd_pkg::cell_t           right_in,
    output mtpd_pkg::cell_t           cell_out
);
    import mtpd_pkg::*;

    cell_t cell_reg, cell_next;
    logic  is_left;
    logic  has_left;
    logic  has_right;

    assign is_left   = (idx[0] == ctl.phase);
    assign has_left  = (idx != '0);
    assign has_right = (idx != CW'(CHANNELS - 1));

    always_comb begin
        cell_next = cell_reg;
        if (ctl.sort_en) begin
            if (is_left) begin
                if (has_right && (cell_reg.pwr > right_in.pwr)) begin
                    cell_next = right_in;
                end
            end else begin
                if (has_left && (left_in.pwr > cell_reg.pwr)) begin
                    cell_next = left_in;
                end
            end
        end else begin
            if (ctl.wr_en && (cell_reg.ch == ctl.wr_ch)) begin
                cell_next.pwr = ctl.wr_pwr;
            end
            if (ctl.inc_en && (ctl.inc_idx == idx) && (cell_reg.cnt != CNT_MAX)) begin
                cell_next.cnt = cell_reg.cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.ch  <= CH_W'(idx);
            cell_reg.cnt <= '0;
        end else begin
            cell_reg.ch  <= cell_next.ch;
            cell_reg.cnt <= cell_next.cnt;
        end
        cell_reg.pwr <= cell_next.pwr;
    end

    assign cell_out = cell_reg;

endmodule

// ===== src/median_threshold_peak_detector.sv =====
// Top level of the median threshold peak detector.
// Sequencer, configuration registers and the chain of mtpd_cell sorting cells.
// Depends on mtpd_pkg and mtpd_cell.
//
//  channel   direction  tdata / data (low bit first)                 side bits
//  s_        in         channel[3:0] power[35:4] pad[39:36]           tlast=is_last tuser=hold
//  m_        out        hit[0] hit_channel[4:1] hit_count[20:5] pad    tuser=ran
//  cfg_      in         index: 0 fudge, 1 ignored mask, 2 ignore all   data 16 bits
//
// A last transaction with hold gives the stored result of the previous
// detection; otherwise detection takes CHANNELS sort phases in the cell chain,
// then the threshold multiply, compare and output states.
// Reset is synchronous: the channel order returns to identity, counters clear.
// A last transaction is held off while an earlier result is still unread.
module median_threshold_peak_detector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // channel, power
    input  logic        s_tlast,
    input  logic        s_tuser,   // hold
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // hit, hit_channel, hit_count
    output logic        m_tuser,   // ran
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import mtpd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SORT = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int MASK_EXT = 2 ** CH_W;

    logic [2:0]          state_reg, state_next;
    logic [PH_W-1:0]     phase_reg, phase_next;
    logic [FUDGE_W-1:0]  fudge_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic                ign_all_reg;
    logic                hit_flag_reg;
    logic [CH_W-1:0]     last_hit_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [PW-1:0]       best_pwr_reg;
    logic [CH_W-1:0]     best_ch_reg;
    logic [CW-1:0]       best_idx_reg;
    logic                found_reg;
    logic                m_valid_reg;
    logic [23:0]         m_data_reg;
    logic                m_user_reg;

    cell_t               cells [CHANNELS];
    cell_ctl_t           ctl;
    logic [MASK_EXT-1:0] mask_ext;
    logic [CHANNELS-1:0] ign;
    logic                best_found;
    logic [CW-1:0]       best_idx;
    logic [CNT_W-1:0]    cnt_sel;
    logic                in_acc;
    logic                out_free;
    logic                hit_now;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && (!s_tlast || out_free);
    assign in_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fudge_reg   <= FUDGE_RESET;
            mask_reg    <= '0;
            ign_all_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FUDGE:      fudge_reg   <= cfg_data[FUDGE_W-1:0];
                REG_IGNORE:     mask_reg    <= cfg_data[MASK_W-1:0];
                REG_IGNORE_ALL: ign_all_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign ctl.wr_en   = in_acc;
    assign ctl.wr_ch   = s_tdata[CH_W-1:0];
    assign ctl.wr_pwr  = s_tdata[CH_W +: PW];
    assign ctl.sort_en = (state_reg == ST_SORT);
    assign ctl.phase   = phase_reg[0];
    assign ctl.inc_en  = (state_reg == ST_CMP) && hit_now;
    assign ctl.inc_idx = best_idx_reg;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
        mtpd_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .idx      (CW'(i)),
            .ctl      (ctl),
            .left_in  (cells[(i == 0) ? 0 : i - 1]),
            .right_in (cells[(i == CHANNELS - 1) ? i : i + 1]),
            .cell_out (cells[i])
        );
    end

    assign mask_ext = MASK_EXT'(mask_reg);

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            ign[i] = ign_all_reg || mask_ext[cells[i].ch];
        end
    end

    always_comb begin
        best_found = 1'b0;
        best_idx   = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (!ign[i]) begin
                best_found = 1'b1;
                best_idx   = CW'(i);
            end
        end
    end

    always_comb begin
        cnt_sel = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            if (cells[i].ch == last_hit_reg) begin
                cnt_sel = cnt_sel | cells[i].cnt;
            end
        end
    end

    assign hit_now = found_reg && ({FUDGE_W'(0), best_pwr_reg} >= thr_reg);

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE: begin
                phase_next = '0;
                if (in_acc && s_tlast && !s_tuser) begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT: begin
                phase_next = phase_reg + PH_W'(1);
                if (phase_reg == PH_W'(CHANNELS - 1)) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: state_next = ST_CMP;
            ST_CMP:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= '0;
            hit_flag_reg <= 1'b0;
            last_hit_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (state_reg == ST_CMP) begin
                hit_flag_reg <= hit_now;
                if (hit_now) begin
                    last_hit_reg <= best_ch_reg;
                end
            end
            if ((state_reg == ST_DONE && out_free) || (in_acc && s_tlast && s_tuser)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EVAL) begin
            thr_reg      <= THR_W'(cells[RANK].pwr) * THR_W'(fudge_reg);
            found_reg    <= best_found;
            best_idx_reg <= best_idx;
            best_pwr_reg <= cells[best_idx].pwr;
            best_ch_reg  <= cells[best_idx].ch;
        end
        if (state_reg == ST_DONE && out_free) begin
            m_user_reg <= 1'b1;
            m_data_reg <= {3'b000, cnt_sel, last_hit_reg, hit_flag_reg};
        end else if (in_acc && s_tlast && s_tuser) begin
            m_user_reg <= 1'b0;
            m_data_reg <= {3'b000, cnt_sel, last_hit_reg, hit_flag_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== tb/sv/median_threshold_peak_detector_tb.sv =====
// Self-checking testbench for median_threshold_peak_detector: directed table, then
// randomized power sets with random idling on input and output, checked by a local predictor.
// Depends on mtpd_pkg and the median_threshold_peak_detector RTL.
module median_threshold_peak_detector_tb;
    import mtpd_pkg::*;

    localparam int LIMIT      = 400000;
    localparam int LONG_HOLD  = 400;
    localparam int SETTLE     = 40;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        logic             ran;
        logic             hit;
        logic [CH_W-1:0]  ch;
        logic [CNT_W-1:0] cnt;
    } detect_rpt_t;

    typedef struct packed {
        logic [CH_W-1:0]     ch;
        logic [PWR_IN_W-1:0] pwr;
        logic                last;
        logic                hold;
        logic                typed;
        detect_rpt_t         want;
    } step_t;

    localparam detect_rpt_t NO_RPT = '0;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tlast;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    median_threshold_peak_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [PW-1:0]      pwr_mem  [CHANNELS];
    logic [CH_W-1:0]    rank_ord [CHANNELS];
    logic [CNT_W-1:0]   hit_cnt  [CHANNELS];
    logic               hit_flag_q;
    logic [CH_W-1:0]    hit_ch_q;
    logic [FUDGE_W-1:0] fudge_q;
    logic [MASK_W-1:0]  mask_q;
    logic               ign_all_q;

    detect_rpt_t expected_reports[$];
    int          mismatches;
    int          reports_seen;
    int          idle_pct;
    int          cycles;
    bit          long_done;
    step_t       dir_tab[24];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int gap_len();
        int r;
        if ($urandom_range(99) >= idle_pct)
            return 0;
        r = $urandom_range(99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < CHANNELS; i++) begin
            pwr_mem[i]  = '0;
            rank_ord[i] = CH_W'(i);
            hit_cnt[i]  = '0;
        end
        hit_flag_q = 1'b0;
        hit_ch_q   = '0;
        fudge_q    = FUDGE_RESET;
        mask_q     = '0;
        ign_all_q  = 1'b0;
    endfunction

    // one input item through the predictor; returns the report if it makes one
    function automatic void detect_step(input step_t st, output bit produced,
                                        output detect_rpt_t rpt);
        logic [CH_W-1:0]  cur;
        logic [CH_W-1:0]  best;
        logic [PW-1:0]    p;
        logic [THR_W-1:0] thr;
        int               j;
        bit               found;
        if (st.ch < CHANNELS)
            pwr_mem[st.ch] = PW'(st.pwr);
        produced = st.last;
        rpt      = NO_RPT;
        if (!st.last)
            return;
        if (!st.hold) begin
            for (int i = 1; i < CHANNELS; i++) begin
                cur = rank_ord[i];
                p   = pwr_mem[cur];
                j   = i;
                while (j > 0 && pwr_mem[rank_ord[j-1]] > p) begin
                    rank_ord[j] = rank_ord[j-1];
                    j--;
                end
                rank_ord[j] = cur;
            end
            thr   = THR_W'(pwr_mem[rank_ord[RANK]]) * THR_W'(fudge_q);
            found = 1'b0;
            best  = '0;
            for (int k = CHANNELS - 1; k >= 0; k--) begin
                if (!found && !(ign_all_q || mask_q[rank_ord[k]])) begin
                    best  = rank_ord[k];
                    found = 1'b1;
                end
            end
            if (found && THR_W'(pwr_mem[best]) >= thr) begin
                hit_flag_q = 1'b1;
                hit_ch_q   = best;
                if (hit_cnt[best] != CNT_MAX)
                    hit_cnt[best]++;
            end else begin
                hit_flag_q = 1'b0;
            end
        end
        rpt.ran = !st.hold;
        rpt.hit = hit_flag_q;
        rpt.ch  = hit_ch_q;
        rpt.cnt = (hit_ch_q < CHANNELS) ? hit_cnt[hit_ch_q] : '0;
    endfunction

    task automatic send_item(input step_t st);
        detect_rpt_t rpt;
        bit          produced;
        int          gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, st.pwr, st.ch};
        s_tlast  <= st.last;
        s_tuser  <= st.hold;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        detect_step(st, produced, rpt);
        if (produced)
            expected_reports.push_back(st.typed ? st.want : rpt);
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_config(input logic [FUDGE_W-1:0] fudge, input logic [MASK_W-1:0] mask,
                                input logic all_ign);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] vals[3];
        idx[0]  = REG_FUDGE;
        idx[1]  = REG_IGNORE;
        idx[2]  = REG_IGNORE_ALL;
        vals[0] = fudge;
        // junk above the register width must be dropped
        vals[1] = {6'($urandom_range(63)), mask};
        vals[2] = {15'($urandom_range(32767)), all_ign};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge aclk);
            while (!cfg_ready)
                @(posedge aclk);
            case (idx[i])
                REG_FUDGE:      fudge_q   = vals[i][FUDGE_W-1:0];
                REG_IGNORE:     mask_q    = vals[i][MASK_W-1:0];
                REG_IGNORE_ALL: ign_all_q = vals[i][0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // one power set: shuffled channels, optional subset, noise and out-of-range tail
    task automatic run_set(inout int sent);
        logic [CH_W-1:0] perm[CHANNELS];
        logic [CH_W-1:0] t;
        logic [PW-1:0]   tie_v;
        step_t           st;
        int              n, r, prof, peak;
        bit              tail_oor;
        for (int i = 0; i < CHANNELS; i++)
            perm[i] = CH_W'(i);
        for (int i = CHANNELS - 1; i > 0; i--) begin
            r       = $urandom_range(i);
            t       = perm[i];
            perm[i] = perm[r];
            perm[r] = t;
        end
        prof     = $urandom_range(3);
        peak     = $urandom_range(CHANNELS - 1);
        tie_v    = $urandom_range(1) ? PW'($urandom) : PW'($urandom_range(3));
        tail_oor = ($urandom_range(9) == 0);
        n = CHANNELS;
        if ($urandom_range(9) == 0)
            n = $urandom_range(1, 3);
        else if ($urandom_range(4) == 0)
            n = $urandom_range(4, CHANNELS - 1);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0) begin
                st      = '0;
                st.ch   = CH_W'($urandom_range(CHANNELS, 15));
                st.pwr  = $urandom;
                st.hold = 1'($urandom_range(1));
                send_item(st);
                sent++;
            end
            st    = '0;
            st.ch = perm[k];
            case (prof)
                0: st.pwr = $urandom;
                1: st.pwr = (perm[k] == peak) ? $urandom : $urandom_range(16'hFFFF);
                2: st.pwr = ($urandom_range(3) == 0) ? tie_v + 1 : tie_v;
                default: begin
                    case ($urandom_range(2))
                        0: st.pwr = '0;
                        1: st.pwr = 1;
                        default: st.pwr = '1;
                    endcase
                end
            endcase
            st.last = (k == n - 1) && !tail_oor;
            st.hold = st.last ? ($urandom_range(4) == 0) : 1'($urandom_range(1));
            send_item(st);
            sent++;
        end
        if (tail_oor) begin
            st      = '0;
            st.ch   = CH_W'($urandom_range(CHANNELS, 15));
            st.pwr  = $urandom;
            st.last = 1'b1;
            st.hold = ($urandom_range(4) == 0);
            send_item(st);
            sent++;
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        detect_rpt_t got;
        detect_rpt_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.ran = m_tuser;
            got.hit = m_tdata[0];
            got.ch  = m_tdata[4:1];
            got.cnt = m_tdata[20:5];
            reports_seen++;
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: ran=%0d hit=%0d ch=%0d cnt=%0d",
                             got.ran, got.hit, got.ch, got.cnt);
            end else begin
                want = expected_reports.pop_front();
                if (got.ran != want.ran || got.hit != want.hit || got.ch != want.ch ||
                    got.cnt != want.cnt) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: exp ran=%0d hit=%0d ch=%0d cnt=%0d, got ran=%0d hit=%0d ch=%0d cnt=%0d",
                                 reports_seen, want.ran, want.hit, want.ch, want.cnt,
                                 got.ran, got.hit, got.ch, got.cnt);
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off to back up the input
    initial begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!long_done && reports_seen >= 10) begin
                long_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    initial begin
        int sent;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        s_tuser      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_FUDGE;
        cfg_data     = '0;
        mismatches   = 0;
        reports_seen = 0;
        long_done    = 1'b0;
        idle_pct     = 30;
        reset_model();

        //            ch     power          last  hold  typed  ran   hit   ch     cnt
        dir_tab = '{
            '{4'd0,  32'h0000_0000, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b0, 4'd0, 16'd0}},
            '{4'd1,  32'h0000_0001, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd2,  32'h0000_0001, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd3,  32'h0000_0001, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd4,  32'h0000_0001, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd5,  32'h0000_0001, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd6,  32'h0000_0001, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd7,  32'h0000_0001, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd8,  32'h0000_0001, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd9,  32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, '{1'b1, 1'b1, 4'd9, 16'd1}},
            '{4'd15, 32'hAAAA_AAAA, 1'b1, 1'b1, 1'b1, '{1'b0, 1'b1, 4'd9, 16'd1}},
            '{4'd12, 32'h5555_5555, 1'b1, 1'b0, 1'b1, '{1'b1, 1'b1, 4'd9, 16'd2}},
            '{4'd9,  32'h0000_0000, 1'b1, 1'b0, 1'b1, '{1'b1, 1'b0, 4'd9, 16'd2}},
            '{4'd3,  32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, NO_RPT},
            '{4'd0,  32'h0001_0000, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd1,  32'h0001_0000, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd2,  32'h0001_0000, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd3,  32'h0001_0000, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd4,  32'h0001_0000, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd5,  32'h0001_0000, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd6,  32'h0001_0000, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd7,  32'h0001_0000, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd8,  32'h0001_0000, 1'b0, 1'b0, 1'b0, NO_RPT},
            '{4'd9,  32'h0001_0000, 1'b1, 1'b0, 1'b0, NO_RPT}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i])
            send_item(dir_tab[i]);
        settle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin write_config(16'd1, '0, 1'b0); idle_pct = 30; end
                1: begin write_config(16'd0, '1, 1'b0); idle_pct = 0; end
                2: begin write_config('1, MASK_W'($urandom), 1'b0); idle_pct = 60; end
                3: begin write_config(16'd2, MASK_W'($urandom), 1'b1); idle_pct = 30; end
                4: begin
                    write_config(FUDGE_W'($urandom_range(8)), MASK_W'($urandom), 1'b0);
                    idle_pct = 30;
                end
                default: begin write_config(FUDGE_RESET, '0, 1'b0); idle_pct = 30; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
                run_set(sent);
            settle();
        end

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
